@@ design/mns_pkg.sv @@
// shared types and constants for the melody note sequencer
// no dependencies; imported by melody_note_sequencer

package mns_pkg;

    localparam int FREQ_W   = 16;
    localparam int DUR_W    = 16;
    localparam int ADDR_W   = 8;
    localparam int POS_W    = 8;
    localparam int MLEN_W   = 9;
    localparam int GAP_W    = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 32;

    localparam logic [MLEN_W-1:0] MLEN_RESET = 9'd1;
    localparam logic [GAP_W-1:0]  GAP_RESET  = 16'd30;

    // operation codes carried on the input tuser
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2,
        OP_LOAD  = 2'd3
    } t_op;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MELODY_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_LENGTH    = 1'd1;

    typedef struct packed {
        logic [DUR_W-1:0]  dur;
        logic [FREQ_W-1:0] freq;
    } t_entry;

endpackage

@@ design/melody_note_sequencer.sv @@
// melody note sequencer top level: note table memory, slot timer and result stage
// depends on mns_pkg (types, operation codes, register indexes)
// result path: second stage (r_s2_v), then output register driving o_m_axis_tvalid
// throughput: one input transaction per cycle unless the result stream stalls
// reset: synchronous active-low; clears control state, melody_length to 1, gap_length to 30
// the note table itself is not cleared; entries read before being loaded are undefined

module melody_note_sequencer #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input stream
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [7:0] entry_address, [23:8] entry_freq, [39:24] entry_duration
    input  logic [mns_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    // [1:0] operation
    input  logic [1:0]                      i_s_axis_tuser,
    // result stream
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [0] tone_enable, [16:1] tone_freq, [17] playing, [25:18] note_position, rest zero
    output logic [mns_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [mns_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [mns_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import mns_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int AW = (IW > ADDR_W) ? IW : ADDR_W;

    // note table: freq and duration side by side, one write and one read port
    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rd;

    // configuration
    logic [MLEN_W-1:0] r_mlen;
    logic [GAP_W-1:0]  r_gap_len;

    // playback state, updated at the input transaction edge
    logic [IW-1:0]    r_index,   n_index;
    logic [DUR_W-1:0] r_elapsed, n_elapsed;
    logic             r_gap,     n_gap;
    logic             r_running, n_running;
    logic             r_tone,    n_tone;
    // cached copy of the table entry at r_index
    t_entry           r_cur,     n_cur;
    // cache refill in flight: the read data register holds the new current entry
    logic             r_fill,    n_fill;

    // result stages
    logic                 r_s2_v;
    logic                 r_out_v;
    logic [M_TDATA_W-1:0] r_out_data;

    // decoded input fields
    t_op              op;
    logic [ADDR_W-1:0] in_addr;
    t_entry           in_entry;
    logic [AW-1:0]    addr_ext;
    logic [IW-1:0]    addr_idx;
    logic             addr_ok;

    logic             s_acc;
    logic             out_free;
    logic             s2_go;

    // current entry and tone with the pending refill folded in
    t_entry           eff_entry;
    logic             eff_tone;

    logic [DUR_W-1:0] el_inc;
    logic [DUR_W-1:0] sounding;
    logic [31:0]      next32;
    logic             wrap;

    logic             rd_en;
    logic [IW-1:0]    rd_addr;
    logic             wr_en;

    logic [M_TDATA_W-1:0] result;

    assign op       = t_op'(i_s_axis_tuser);
    assign in_addr  = i_s_axis_tdata[7:0];
    assign in_entry.freq = i_s_axis_tdata[23:8];
    assign in_entry.dur  = i_s_axis_tdata[39:24];
    assign addr_ext = AW'(in_addr);
    assign addr_idx = addr_ext[IW-1:0];
    assign addr_ok  = 32'(in_addr) < 32'(TABLE_DEPTH);

    // the result stage must move on before a new transaction changes the state it shows
    assign out_free        = !r_out_v || i_m_axis_tready;
    assign s2_go           = r_s2_v && out_free;
    assign o_s_axis_tready = !r_s2_v || out_free;
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;

    assign eff_entry = r_fill ? r_rd : r_cur;
    assign eff_tone  = r_fill ? (r_rd.freq != '0) : r_tone;

    // saturating millisecond count and sounding part of the slot
    assign el_inc   = (r_elapsed == '1) ? r_elapsed : r_elapsed + DUR_W'(1);
    assign sounding = (eff_entry.dur > r_gap_len) ? eff_entry.dur - r_gap_len
                                                  : eff_entry.dur;

    // next index wraps at melody_length or the table end
    assign next32 = 32'(r_index) + 32'd1;
    assign wrap   = (next32 >= 32'(r_mlen)) || (next32 >= 32'(TABLE_DEPTH));

    always_comb begin
        n_index   = r_index;
        n_elapsed = r_elapsed;
        n_gap     = r_gap;
        n_running = r_running;
        n_tone    = eff_tone;
        n_cur     = eff_entry;
        n_fill    = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = '0;
        wr_en     = 1'b0;
        if (s_acc) begin
            unique case (op)
                OP_TICK: begin
                    if (r_running) begin
                        n_elapsed = el_inc;
                        if (!r_gap) begin
                            if (el_inc >= sounding) begin
                                n_tone = 1'b0;
                                n_gap  = 1'b1;
                            end
                        end else if (el_inc >= eff_entry.dur) begin
                            // slot over: next entry, fetched from the table
                            n_index   = wrap ? '0 : IW'(next32);
                            n_elapsed = '0;
                            n_gap     = 1'b0;
                            n_fill    = 1'b1;
                            rd_en     = 1'b1;
                            rd_addr   = wrap ? '0 : IW'(next32);
                        end
                    end
                end
                OP_START: begin
                    n_index   = '0;
                    n_running = 1'b1;
                    n_elapsed = '0;
                    n_gap     = 1'b0;
                    n_fill    = 1'b1;
                    rd_en     = 1'b1;
                    rd_addr   = '0;
                end
                OP_STOP: begin
                    if (r_running) begin
                        n_running = 1'b0;
                        n_gap     = 1'b0;
                        n_tone    = 1'b0;
                    end
                end
                OP_LOAD: begin
                    if (addr_ok) begin
                        wr_en = 1'b1;
                        // a load to the playing entry takes effect at once
                        if (addr_idx == r_index) begin
                            n_cur = in_entry;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // table memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[addr_idx] <= in_entry;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mlen    <= MLEN_RESET;
            r_gap_len <= GAP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_MELODY_LENGTH: r_mlen    <= i_cfg_wdata[MLEN_W-1:0];
                CFG_GAP_LENGTH:    r_gap_len <= i_cfg_wdata[GAP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // playback state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index   <= '0;
            r_elapsed <= '0;
            r_gap     <= 1'b0;
            r_running <= 1'b0;
            r_tone    <= 1'b0;
            r_fill    <= 1'b0;
        end else begin
            r_index   <= n_index;
            r_elapsed <= n_elapsed;
            r_gap     <= n_gap;
            r_running <= n_running;
            r_tone    <= n_tone;
            r_fill    <= n_fill;
        end
    end

    // entry cache carries no reset; it is refilled by start and at each slot change
    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
    end

    // result of the transaction in the second stage: state after that transaction
    always_comb begin
        result        = '0;
        result[0]     = eff_tone;
        result[16:1]  = eff_tone ? eff_entry.freq : '0;
        result[17]    = r_running;
        result[25:18] = POS_W'(r_index);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (s_acc) begin
                r_s2_v <= 1'b1;
            end else if (s2_go) begin
                r_s2_v <= 1'b0;
            end
            if (s2_go) begin
                r_out_v <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_go) begin
            r_out_data <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = r_out_data;

`ifndef ASSERT_OFF
    // a refill always belongs to the transaction in the second stage
    a_fill_in_s2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill |-> r_s2_v)
        else $error("refill pending without a transaction in the second stage");

    // start lands on entry zero, running, with a refill in flight
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && op == OP_START) |=> (r_running && r_index == '0 && r_fill))
        else $error("start did not restart at entry zero");

    // the gap part of a slot is silent
    a_gap_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gap |-> !r_tone)
        else $error("tone active during the gap");

    // nothing sounds while stopped
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_running |-> (!eff_tone && !r_gap))
        else $error("tone or gap active while stopped");
`endif

endmodule
